// ----- hw/rtl/esa_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder setpoint adjuster package
// Field widths and request and register codes shared by the interfaces, the
// core and the checker, and the setpoint step functions used by the core.
// ----------------------------------------------------------------------------
package esa_pkg;

	localparam int TEMP_W  = 12;
	localparam int TIME_W  = 17;
	localparam int SPEED_W = 10;
	localparam int COUNT_W = 8;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic REQ_EDGE  = 1'b0;
	localparam logic REQ_TICK  = 1'b1;
	localparam logic KNOB_TEMP = 1'b0;
	localparam logic KNOB_TIME = 1'b1;
	localparam logic DIR_UP    = 1'b0;

	localparam logic [1:0] REG_TEMP_MAX = 2'd0;
	localparam logic [1:0] REG_TIME_MAX = 2'd1;
	localparam logic [1:0] REG_FAST_THR = 2'd2;

	localparam logic [TEMP_W-1:0]  TEMP_MAX_RST = 12'd4000;
	localparam logic [TIME_W-1:0]  TIME_MAX_RST = 17'd86400;
	localparam logic [SPEED_W-1:0] FAST_THR_RST = 10'd30;

	// Reciprocal constants: floor(v * M / 2**S) equals v / d over the field range.
	localparam logic [23:0] DIV10_MUL   = 24'd3277;
	localparam int          DIV10_SHIFT = 15;
	localparam logic [34:0] DIV60_MUL   = 35'd139811;
	localparam int          DIV60_SHIFT = 23;

	localparam logic signed [13:0] TEMP_SNAP       = 14'sd1000;
	localparam logic signed [13:0] TEMP_FAST_UP    = 14'sd980;
	localparam logic signed [13:0] TEMP_FAST_DN    = 14'sd1020;
	localparam logic signed [13:0] TEMP_FINE       = 14'sd5;
	localparam logic signed [13:0] TEMP_COARSE     = 14'sd10;
	localparam logic signed [13:0] TEMP_FAST_STEP  = 14'sd20;

	localparam logic signed [18:0] TIME_SNAP        = 19'sd3600;
	localparam logic signed [18:0] TIME_FINE_SLOW   = 19'sd5;
	localparam logic signed [18:0] TIME_FINE_FAST   = 19'sd30;
	localparam logic signed [18:0] TIME_COARSE_SLOW = 19'sd60;
	localparam logic signed [18:0] TIME_COARSE_FAST = 19'sd300;

	function automatic logic [TEMP_W-1:0] temp_step(
		input logic [TEMP_W-1:0] v,
		input logic              up,
		input logic              fast,
		input logic [TEMP_W-1:0] vmax
	);
		logic [23:0]        prod;
		logic [TEMP_W-1:0]  quo;
		logic [3:0]         rem;
		logic signed [13:0] sv;
		logic signed [13:0] srem;
		logic signed [13:0] n;
		logic [TEMP_W-1:0]  res;
		prod = 24'(v) * DIV10_MUL;
		quo  = TEMP_W'(prod >> DIV10_SHIFT);
		rem  = 4'(v - quo * 12'd10);
		sv   = signed'({2'b00, v});
		srem = signed'({10'd0, rem});
		if (up) begin
			if (!fast) begin
				n = (sv < TEMP_SNAP) ? sv + TEMP_FINE : sv - srem + TEMP_COARSE;
			end else begin
				n = sv + TEMP_FAST_STEP - ((rem != 4'd0 && sv > TEMP_FAST_UP) ? srem : 14'sd0);
			end
			res = (n > signed'({2'b00, vmax})) ? vmax : TEMP_W'(n);
		end else begin
			if (!fast) begin
				n = (sv < TEMP_SNAP) ? sv - TEMP_FINE : sv - srem - TEMP_COARSE;
			end else begin
				n = sv - TEMP_FAST_STEP - ((rem != 4'd0 && sv > TEMP_FAST_DN) ? srem : 14'sd0);
			end
			res = (n < 14'sd0) ? '0 : TEMP_W'(n);
		end
		return res;
	endfunction

	function automatic logic [TIME_W-1:0] time_step(
		input logic [TIME_W-1:0] v,
		input logic              up,
		input logic              fast,
		input logic [TIME_W-1:0] vmax
	);
		logic [34:0]        prod;
		logic [TIME_W-1:0]  quo;
		logic [5:0]         rem;
		logic signed [18:0] sv;
		logic signed [18:0] srem;
		logic signed [18:0] fine;
		logic signed [18:0] coarse;
		logic signed [18:0] n;
		logic [TIME_W-1:0]  res;
		prod   = 35'(v) * DIV60_MUL;
		quo    = TIME_W'(prod >> DIV60_SHIFT);
		rem    = 6'(v - quo * 17'd60);
		sv     = signed'({2'b00, v});
		srem   = signed'({13'd0, rem});
		fine   = fast ? TIME_FINE_FAST : TIME_FINE_SLOW;
		coarse = fast ? TIME_COARSE_FAST : TIME_COARSE_SLOW;
		if (up) begin
			if (sv < TIME_SNAP) begin
				n = sv + fine;
			end else if (rem != 6'd0) begin
				n = sv - srem;
			end else begin
				n = sv + coarse;
			end
			res = (n > signed'({2'b00, vmax})) ? vmax : TIME_W'(n);
		end else begin
			if (sv <= TIME_SNAP) begin
				n = sv - fine;
			end else if (rem != 6'd0) begin
				n = sv - srem;
			end else begin
				n = sv - coarse;
			end
			res = (n < 19'sd0) ? '0 : TIME_W'(n);
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/esa_if.sv -----
// ----------------------------------------------------------------------------
// Encoder setpoint adjuster channels
// Request channel carrying encoder edges and ticks, and result channel
// carrying the setpoints and knob speeds.
// ----------------------------------------------------------------------------
interface esa_item_if;
	logic valid;
	logic ready;
	logic req_type;
	logic knob;
	logic b_level;
	logic display_off;

	modport source (output valid, req_type, knob, b_level, display_off, input ready);
	modport sink (input valid, req_type, knob, b_level, display_off, output ready);
endinterface

interface esa_result_if;
	logic                         valid;
	logic                         ready;
	logic [esa_pkg::TEMP_W-1:0]   temp_set;
	logic [esa_pkg::TIME_W-1:0]   time_set;
	logic                         adjusted;
	logic [esa_pkg::SPEED_W-1:0]  temp_knob_speed;
	logic [esa_pkg::SPEED_W-1:0]  time_knob_speed;

	modport source (
		output valid, temp_set, time_set, adjusted, temp_knob_speed, time_knob_speed,
		input  ready
	);
	modport sink (
		input  valid, temp_set, time_set, adjusted, temp_knob_speed, time_knob_speed,
		output ready
	);
endinterface

// ----- hw/rtl/encoder_setpoint_adjuster_core.sv -----
// ----------------------------------------------------------------------------
// Encoder setpoint adjuster core
// Path: input register, then the setpoint update into the result register.
// Throughput: one request per cycle while the result channel is not stalled;
// the setpoint update between the two registers sets that figure.
// Reset: arst_n clears setpoints, edge counts, speeds and valid flags and
// loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_setpoint_adjuster_core (
	input  logic                         clk,
	input  logic                         arst_n,
	esa_item_if.sink                     item,
	esa_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [esa_pkg::ADDR_W-1:0]   paddr,
	input  logic [esa_pkg::DATA_W-1:0]   pwdata,
	output logic [esa_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import esa_pkg::*;

	logic [TEMP_W-1:0]  temp_max_q;
	logic [TIME_W-1:0]  time_max_q;
	logic [SPEED_W-1:0] fast_thr_q;
	logic [1:0]         reg_idx;
	logic               cfg_wr;

	logic [TEMP_W-1:0]  temp_sp_q;
	logic [TIME_W-1:0]  time_sp_q;
	logic [COUNT_W-1:0] temp_cnt_q;
	logic [COUNT_W-1:0] time_cnt_q;
	logic [SPEED_W-1:0] temp_spd_q;
	logic [SPEED_W-1:0] time_spd_q;

	logic valid_s1;
	logic req_type_s1;
	logic knob_s1;
	logic b_level_s1;
	logic display_off_s1;

	logic               valid_s2;
	logic [TEMP_W-1:0]  temp_set_s2;
	logic [TIME_W-1:0]  time_set_s2;
	logic               adjusted_s2;
	logic [SPEED_W-1:0] temp_spd_s2;
	logic [SPEED_W-1:0] time_spd_s2;

	logic               adv;
	logic               in_acc;
	logic               step_en;
	logic               up;
	logic [TEMP_W-1:0]  temp_sp_d;
	logic [TIME_W-1:0]  time_sp_d;
	logic [COUNT_W-1:0] temp_cnt_d;
	logic [COUNT_W-1:0] time_cnt_d;
	logic [SPEED_W-1:0] temp_spd_d;
	logic [SPEED_W-1:0] time_spd_d;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			REG_TEMP_MAX: prdata = DATA_W'(temp_max_q);
			REG_TIME_MAX: prdata = DATA_W'(time_max_q);
			REG_FAST_THR: prdata = DATA_W'(fast_thr_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_max_q <= TEMP_MAX_RST;
			time_max_q <= TIME_MAX_RST;
			fast_thr_q <= FAST_THR_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TEMP_MAX: temp_max_q <= pwdata[TEMP_W-1:0];
				REG_TIME_MAX: time_max_q <= pwdata[TIME_W-1:0];
				REG_FAST_THR: fast_thr_q <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign in_acc     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_type_s1    <= item.req_type;
			knob_s1        <= item.knob;
			b_level_s1     <= item.b_level;
			display_off_s1 <= item.display_off;
		end
	end

	assign step_en = (req_type_s1 == REQ_EDGE) && !display_off_s1;
	assign up      = (b_level_s1 == DIR_UP);

	always_comb begin
		temp_sp_d  = temp_sp_q;
		time_sp_d  = time_sp_q;
		temp_cnt_d = temp_cnt_q;
		time_cnt_d = time_cnt_q;
		temp_spd_d = temp_spd_q;
		time_spd_d = time_spd_q;
		if (req_type_s1 == REQ_TICK) begin
			temp_spd_d = SPEED_W'(temp_cnt_q) + SPEED_W'({temp_cnt_q, 1'b0});
			time_spd_d = SPEED_W'(time_cnt_q) + SPEED_W'({time_cnt_q, 1'b0});
			temp_cnt_d = '0;
			time_cnt_d = '0;
		end else if (step_en) begin
			if (knob_s1 == KNOB_TEMP) begin
				if (temp_cnt_q != '1) begin
					temp_cnt_d = temp_cnt_q + 1'b1;
				end
				temp_sp_d = temp_step(temp_sp_q, up, temp_spd_q >= fast_thr_q, temp_max_q);
			end else begin
				if (time_cnt_q != '1) begin
					time_cnt_d = time_cnt_q + 1'b1;
				end
				time_sp_d = time_step(time_sp_q, up, time_spd_q >= fast_thr_q, time_max_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_sp_q  <= '0;
			time_sp_q  <= '0;
			temp_cnt_q <= '0;
			time_cnt_q <= '0;
			temp_spd_q <= '0;
			time_spd_q <= '0;
		end else if (adv) begin
			temp_sp_q  <= temp_sp_d;
			time_sp_q  <= time_sp_d;
			temp_cnt_q <= temp_cnt_d;
			time_cnt_q <= time_cnt_d;
			temp_spd_q <= temp_spd_d;
			time_spd_q <= time_spd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_set_s2 <= temp_sp_d;
			time_set_s2 <= time_sp_d;
			adjusted_s2 <= step_en;
			temp_spd_s2 <= temp_spd_d;
			time_spd_s2 <= time_spd_d;
		end
	end

	assign result.valid           = valid_s2;
	assign result.temp_set        = temp_set_s2;
	assign result.time_set        = time_set_s2;
	assign result.adjusted        = adjusted_s2;
	assign result.temp_knob_speed = temp_spd_s2;
	assign result.time_knob_speed = time_spd_s2;

endmodule

// ----- hw/rtl/esa_checker.sv -----
// ----------------------------------------------------------------------------
// Encoder setpoint adjuster checker
// Port-level checks on request and result flow and register readback,
// bound to the core.
// ----------------------------------------------------------------------------
module esa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [esa_pkg::TEMP_W-1:0]   temp_set,
	input logic [esa_pkg::TIME_W-1:0]   time_set,
	input logic                         adjusted,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [esa_pkg::ADDR_W-1:0]   paddr,
	input logic [esa_pkg::DATA_W-1:0]   pwdata,
	input logic [esa_pkg::DATA_W-1:0]   prdata
);
	import esa_pkg::*;

	logic [1:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(temp_set) && $stable(time_set) && $stable(adjusted))
		else $error("Result changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != 2'd0)
		else $error("Result presented without an outstanding request.");

	assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("More than two requests held inside the core.");

	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_TEMP_MAX |=>
			!(psel && !pwrite && paddr[ADDR_W-1:2] == REG_TEMP_MAX) ||
			prdata == DATA_W'($past(pwdata[TEMP_W-1:0])))
		else $error("Temperature maximum readback mismatch.");

endmodule

bind encoder_setpoint_adjuster_core esa_checker u_esa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.temp_set     (result.temp_set),
	.time_set     (result.time_set),
	.adjusted     (result.adjusted),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

// ----- sim/tb_encoder_setpoint_adjuster_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder setpoint adjuster core testbench
// Drives encoder edge and speed tick requests through the request channel,
// stalls both channels at random, and compares every result against a local
// setpoint predictor. The limit registers and the fast threshold are set over
// the register port between phases: extremes, reset defaults, random and fixed values.
// ----------------------------------------------------------------------------
module tb_encoder_setpoint_adjuster_core;
	import esa_pkg::*;

	localparam logic       DIR_DOWN   = ~DIR_UP;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int         MAX_PRINTS = 40;

	typedef struct packed {
		logic req_type;
		logic knob;
		logic b_level;
		logic display_off;
	} knob_event_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  temp_set;
		logic [TIME_W-1:0]  time_set;
		logic               adjusted;
		logic [SPEED_W-1:0] temp_speed;
		logic [SPEED_W-1:0] time_speed;
	} setpoint_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              ev_valid = 1'b0;
	knob_event_t       cur_ev = '0;
	logic              res_ready = 1'b0;
	logic              apb_sel = 1'b0;
	logic              apb_en = 1'b0;
	logic              apb_wr = 1'b0;
	logic [ADDR_W-1:0] apb_addr = '0;
	logic [DATA_W-1:0] apb_wdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	esa_item_if   item_ch ();
	esa_result_if result_ch ();

	assign item_ch.valid       = ev_valid;
	assign item_ch.req_type    = cur_ev.req_type;
	assign item_ch.knob        = cur_ev.knob;
	assign item_ch.b_level     = cur_ev.b_level;
	assign item_ch.display_off = cur_ev.display_off;
	assign result_ch.ready     = res_ready;

	encoder_setpoint_adjuster_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (apb_sel),
		.penable (apb_en),
		.pwrite  (apb_wr),
		.paddr   (apb_addr),
		.pwdata  (apb_wdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	knob_event_t      pending_events[$];
	setpoint_report_t predicted_outputs[$];
	logic             steady = 1'b0;

	logic [TEMP_W-1:0]  temp_lim = TEMP_MAX_RST;
	logic [TIME_W-1:0]  time_lim = TIME_MAX_RST;
	logic [SPEED_W-1:0] fast_thr = FAST_THR_RST;

	logic [TEMP_W-1:0]  temp_sp = '0;
	logic [TIME_W-1:0]  time_sp = '0;
	logic [7:0]         temp_count = '0;
	logic [7:0]         time_count = '0;
	logic [SPEED_W-1:0] temp_speed = '0;
	logic [SPEED_W-1:0] time_speed = '0;

	int errors = 0;
	int n_adjust = 0;
	int n_ignored = 0;
	int n_ticks = 0;
	int n_checked = 0;
	int n_settings = 0;

	function automatic int next_temp(int v, bit up, bit fast);
		int n;
		if (up) begin
			if (!fast) begin
				n = (v < 1000) ? v + 5 : v - v % 10 + 10;
			end else begin
				n = v + 20;
				if (n % 10 != 0 && n > 1000) n = n - n % 10;
			end
			if (n > int'(temp_lim)) n = int'(temp_lim);
		end else begin
			if (!fast) begin
				n = (v < 1000) ? v - 5 : v - v % 10 - 10;
			end else begin
				n = v - 20;
				if (n % 10 != 0 && n > 1000) n = n - n % 10;
			end
			if (n < 0) n = 0;
		end
		return n;
	endfunction

	function automatic int next_time(int v, bit up, bit fast);
		int fine;
		int coarse;
		int n;
		fine   = fast ? 30 : 5;
		coarse = fast ? 300 : 60;
		if (up) begin
			if (v < 3600) n = v + fine;
			else if (v % 60 != 0) n = v - v % 60;
			else n = v + coarse;
			if (n > int'(time_lim)) n = int'(time_lim);
		end else begin
			if (v <= 3600) n = v - fine;
			else if (v % 60 != 0) n = v - v % 60;
			else n = v - coarse;
			if (n < 0) n = 0;
		end
		return n;
	endfunction

	function automatic setpoint_report_t predict_setpoints(knob_event_t ev);
		setpoint_report_t r;
		r.adjusted = 1'b0;
		if (ev.req_type == REQ_TICK) begin
			temp_speed = SPEED_W'(int'(temp_count) * 3);
			time_speed = SPEED_W'(int'(time_count) * 3);
			temp_count = '0;
			time_count = '0;
			n_ticks++;
		end else if (ev.display_off) begin
			n_ignored++;
		end else begin
			r.adjusted = 1'b1;
			n_adjust++;
			if (ev.knob == KNOB_TEMP) begin
				if (temp_count != 8'd255) temp_count = temp_count + 8'd1;
				temp_sp = TEMP_W'(next_temp(int'(temp_sp), ev.b_level == DIR_UP,
					temp_speed >= fast_thr));
			end else begin
				if (time_count != 8'd255) time_count = time_count + 8'd1;
				time_sp = TIME_W'(next_time(int'(time_sp), ev.b_level == DIR_UP,
					time_speed >= fast_thr));
			end
		end
		r.temp_set   = temp_sp;
		r.time_set   = time_sp;
		r.temp_speed = temp_speed;
		r.time_speed = time_speed;
		return r;
	endfunction

	task automatic report(string msg);
		if (errors < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid <= 1'b0;
		end else begin
			if (ev_valid && item_ch.ready) predicted_outputs.push_back(predict_setpoints(cur_ev));
			if (!ev_valid || item_ch.ready) begin
				if (pending_events.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
					cur_ev   <= pending_events.pop_front();
					ev_valid <= 1'b1;
				end else begin
					ev_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		setpoint_report_t got;
		setpoint_report_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (result_ch.valid && res_ready) begin
				got.temp_set   = result_ch.temp_set;
				got.time_set   = result_ch.time_set;
				got.adjusted   = result_ch.adjusted;
				got.temp_speed = result_ch.temp_knob_speed;
				got.time_speed = result_ch.time_knob_speed;
				if (predicted_outputs.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					want = predicted_outputs.pop_front();
					n_checked++;
					if (got.temp_set !== want.temp_set)
						report($sformatf("temp_set %0d, expected %0d", got.temp_set, want.temp_set));
					if (got.time_set !== want.time_set)
						report($sformatf("time_set %0d, expected %0d", got.time_set, want.time_set));
					if (got.adjusted !== want.adjusted)
						report($sformatf("adjusted %0b, expected %0b", got.adjusted, want.adjusted));
					if (got.temp_speed !== want.temp_speed)
						report($sformatf("temp_knob_speed %0d, expected %0d",
							got.temp_speed, want.temp_speed));
					if (got.time_speed !== want.time_speed)
						report($sformatf("time_knob_speed %0d, expected %0d",
							got.time_speed, want.time_speed));
				end
			end
			res_ready <= steady || ($urandom_range(99) >= 10);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] data);
		@(posedge clk);
		apb_sel   <= 1'b1;
		apb_en    <= 1'b0;
		apb_wr    <= 1'b1;
		apb_addr  <= {idx, 2'b00};
		apb_wdata <= data;
		@(posedge clk);
		apb_en <= 1'b1;
		do @(posedge clk); while (!pready);
		apb_sel <= 1'b0;
		apb_en  <= 1'b0;
		apb_wr  <= 1'b0;
		case (idx)
			REG_TEMP_MAX: temp_lim = data[TEMP_W-1:0];
			REG_TIME_MAX: time_lim = data[TIME_W-1:0];
			REG_FAST_THR: fast_thr = data[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [DATA_W-1:0] tmax, logic [DATA_W-1:0] smax,
			logic [DATA_W-1:0] thr);
		write_reg(REG_TEMP_MAX, tmax);
		write_reg(REG_TIME_MAX, smax);
		write_reg(REG_FAST_THR, thr);
		n_settings++;
	endtask

	task automatic drain();
		while (pending_events.size() != 0 || ev_valid || predicted_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_burst(logic knob, logic dir, int len);
		knob_event_t ev;
		for (int i = 0; i < len; i++) begin
			ev = {REQ_EDGE, knob, dir, 1'b0};
			ev.display_off = ($urandom_range(99) < 5);
			pending_events.push_back(ev);
		end
	endtask

	task automatic fill_random(int count, int up_pct);
		knob_event_t ev;
		int made;
		int pick;
		int len;
		logic knob;
		logic dir;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				ev = knob_event_t'($urandom_range(15));
				ev.req_type = REQ_TICK;
				pending_events.push_back(ev);
				made++;
			end else if (pick < 10) begin
				ev = knob_event_t'($urandom_range(15));
				pending_events.push_back(ev);
				if (ev.req_type == REQ_TICK || !ev.display_off) made++;
			end else begin
				knob = 1'($urandom_range(1));
				dir  = ($urandom_range(99) < up_pct) ? DIR_UP : DIR_DOWN;
				len  = ($urandom_range(39) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 25);
				push_burst(knob, dir, len);
				made += len;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_events.push_back({REQ_TICK, KNOB_TEMP, DIR_UP, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_UP, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_DOWN, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_DOWN, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TIME, DIR_UP, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TIME, DIR_DOWN, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TIME, DIR_DOWN, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_UP, 1'b1});
		pending_events.push_back({REQ_EDGE, KNOB_TIME, DIR_DOWN, 1'b1});
		pending_events.push_back({REQ_TICK, KNOB_TIME, DIR_DOWN, 1'b1});
		repeat (10) pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_UP, 1'b0});
		pending_events.push_back({REQ_TICK, KNOB_TEMP, DIR_UP, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_UP, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TEMP, DIR_DOWN, 1'b0});
		pending_events.push_back({REQ_EDGE, KNOB_TIME, DIR_UP, 1'b0});
		drain();

		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		fill_random(160, 75);
		drain();

		write_reg(REG_UNUSED, $urandom);
		configure(32'd0, 32'd0, 32'h3FF);
		fill_random(70, 50);
		drain();

		configure(32'd4000, 32'd86400, 32'd30);
		steady = 1'b1;
		push_burst(KNOB_TEMP, DIR_UP, 270);
		push_burst(KNOB_TIME, DIR_UP, 270);
		pending_events.push_back({REQ_TICK, KNOB_TIME, DIR_UP, 1'b0});
		fill_random(100, 70);
		drain();
		steady = 1'b0;

		configure($urandom_range(900, 4095), $urandom_range(3000, 131071), $urandom_range(40));
		fill_random(140, 40);
		drain();

		configure(32'd1000, 32'd3600, 32'd15);
		fill_random(115, 60);
		drain();

		$display("Checked %0d results: %0d setpoint steps, %0d ignored edges, %0d speed ticks.",
			n_checked, n_adjust, n_ignored, n_ticks);
		$display("Register settings applied: %0d; mismatches: %0d.", n_settings, errors);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d requests queued and %0d results outstanding.",
			pending_events.size(), predicted_outputs.size());
		$display("FAILURE");
		$finish;
	end

endmodule
